// ----- hdl/att_pkg.sv -----
// Shared widths, types, register codes and arctangent table of the tilt angle block.
`default_nettype none

package att_pkg;

  // Rotation stages of each arctangent pipeline; the table has 24 entries.
  localparam int CORDIC_STAGES = 16;
  localparam int CORDIC_RUN    = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

  localparam int RAW_W      = 16;
  localparam int OFF_W      = 13;
  localparam int CAL_W      = 17;
  localparam int AB_W       = 16;
  localparam int SQ_W       = 2 * AB_W;
  localparam int SUM_W      = 32;
  localparam int ROOT_W     = 32;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int REM_W      = ROOT_W + 4;
  localparam int FRAC_W     = 16;
  localparam int CX_W       = 36;
  localparam int ACC_W      = 29;
  localparam int ANG_W      = 15;

  localparam int ANG_MAX     = 23040;
  localparam int ANG_ROUND   = 2048;
  localparam int ANG_SHIFT   = 12;
  localparam int ANG_QUARTER = 47185920;

  localparam int CFG_ADDR_W = 2;

  typedef logic signed [RAW_W-1:0] raw_t;
  typedef logic signed [OFF_W-1:0] off_t;
  typedef logic signed [CAL_W-1:0] cal_t;
  typedef logic signed [CX_W-1:0]  cx_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [ANG_W-1:0]        ang_t;
  typedef logic [CFG_ADDR_W-1:0]   cfg_addr_t;

  localparam cfg_addr_t CFG_OFFSET_X = 2'd0;
  localparam cfg_addr_t CFG_OFFSET_Y = 2'd1;
  localparam cfg_addr_t CFG_OFFSET_Z = 2'd2;

  localparam off_t OFF_X_RST = 13'sd164;
  localparam off_t OFF_Y_RST = -13'sd459;
  localparam off_t OFF_Z_RST = -13'sd25;

  // atan(2^-i) in units of 2^-19 degree
  function automatic acc_t atan_entry(input int idx);
    case (idx)
      0:       atan_entry = acc_t'(23592960);
      1:       atan_entry = acc_t'(13927738);
      2:       atan_entry = acc_t'(7359034);
      3:       atan_entry = acc_t'(3735561);
      4:       atan_entry = acc_t'(1875029);
      5:       atan_entry = acc_t'(938429);
      6:       atan_entry = acc_t'(469329);
      7:       atan_entry = acc_t'(234679);
      8:       atan_entry = acc_t'(117341);
      9:       atan_entry = acc_t'(58671);
      10:      atan_entry = acc_t'(29335);
      11:      atan_entry = acc_t'(14668);
      12:      atan_entry = acc_t'(7334);
      13:      atan_entry = acc_t'(3667);
      14:      atan_entry = acc_t'(1833);
      15:      atan_entry = acc_t'(917);
      16:      atan_entry = acc_t'(458);
      17:      atan_entry = acc_t'(229);
      18:      atan_entry = acc_t'(115);
      19:      atan_entry = acc_t'(57);
      20:      atan_entry = acc_t'(29);
      21:      atan_entry = acc_t'(14);
      22:      atan_entry = acc_t'(7);
      23:      atan_entry = acc_t'(4);
      default: atan_entry = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- hdl/att_if.sv -----
// Channel interfaces: sample input, angle result and register write port.
`default_nettype none

interface att_in_if import att_pkg::*; ;
  logic valid;
  logic ready;
  raw_t accel_raw_x;
  raw_t accel_raw_y;
  raw_t accel_raw_z;

  modport source (output valid, output accel_raw_x, output accel_raw_y, output accel_raw_z,
                  input ready);
  modport sink   (input valid, input accel_raw_x, input accel_raw_y, input accel_raw_z,
                  output ready);
endinterface

interface att_out_if import att_pkg::*; ;
  logic valid;
  logic ready;
  ang_t tilt_from_z;
  ang_t plane_angle;
  logic degenerate;

  modport source (output valid, output tilt_from_z, output plane_angle, output degenerate,
                  input ready);
  modport sink   (input valid, input tilt_from_z, input plane_angle, input degenerate,
                  output ready);
endinterface

interface att_cfg_if import att_pkg::*; ;
  logic      valid;
  logic      ready;
  cfg_addr_t addr;
  off_t      wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// ----- hdl/att_cordic.sv -----
// Pipelined vectoring arctangent: one rotation per register stage, rounded to 1/128 degree.
`default_nettype none

module att_cordic import att_pkg::*; (
  input  wire logic clk,
  input  wire logic en,
  input  wire cx_t  x_in,
  input  wire cx_t  y_in,
  output ang_t      angle
);

  localparam int Q_W = ACC_W - ANG_SHIFT;

  cx_t  xs_r  [CORDIC_RUN+1];
  cx_t  ys_r  [CORDIC_RUN+1];
  acc_t acc_r [CORDIC_RUN+1];

  cx_t  dx      [CORDIC_RUN];
  cx_t  dy      [CORDIC_RUN];
  cx_t  xs_nxt  [CORDIC_RUN];
  cx_t  ys_nxt  [CORDIC_RUN];
  acc_t acc_nxt [CORDIC_RUN];

  logic [ACC_W-1:0] acc_pos;
  logic [ACC_W-1:0] acc_rnd;
  logic [Q_W-1:0]   ang_q;

  always_comb begin
    for (int i = 0; i < CORDIC_RUN; i++) begin
      dx[i] = ys_r[i] >>> i;
      dy[i] = xs_r[i] >>> i;
      if (!ys_r[i][CX_W-1]) begin
        xs_nxt[i]  = xs_r[i] + dx[i];
        ys_nxt[i]  = ys_r[i] - dy[i];
        acc_nxt[i] = acc_r[i] + atan_entry(i);
      end else begin
        xs_nxt[i]  = xs_r[i] - dx[i];
        ys_nxt[i]  = ys_r[i] + dy[i];
        acc_nxt[i] = acc_r[i] - atan_entry(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // pre-rotate by 90 degrees when the vector points into the left half plane
      if (x_in[CX_W-1]) begin
        xs_r[0]  <= y_in;
        ys_r[0]  <= -x_in;
        acc_r[0] <= acc_t'(ANG_QUARTER);
      end else begin
        xs_r[0]  <= x_in;
        ys_r[0]  <= y_in;
        acc_r[0] <= '0;
      end
      for (int i = 0; i < CORDIC_RUN; i++) begin
        xs_r[i+1]  <= xs_nxt[i];
        ys_r[i+1]  <= ys_nxt[i];
        acc_r[i+1] <= acc_nxt[i];
      end
    end
  end

  // clamp at zero, round half up to 1/128 degree, clamp at 180 degrees
  always_comb begin
    acc_pos = acc_r[CORDIC_RUN][ACC_W-1] ? '0 : acc_r[CORDIC_RUN];
    acc_rnd = acc_pos + ACC_W'(ANG_ROUND);
    ang_q   = acc_rnd[ACC_W-1:ANG_SHIFT];
    angle   = (ang_q > Q_W'(ANG_MAX)) ? ANG_W'(ANG_MAX) : ang_q[ANG_W-1:0];
  end

endmodule

`default_nettype wire

// ----- hdl/accel_tilt_angles_core.sv -----
// Tilt angles of one three-axis accelerometer sample, fully pipelined.
// One sample enters per clock: calibrated x = raw z + offset_x, y = raw y + offset_y,
// z = raw x + offset_z. Out come tilt_from_z = atan2(sqrt(x^2+y^2), z) and
// plane_angle = atan2(|y|, x), both in 1/128 degree over 0..23040, plus degenerate when
// x and y are both zero (plane_angle then 0; with z also zero both angles are 0).
// From acceptance to the result register a sample passes three front stages (offset,
// magnitude, squares), 33 stages of the bit-per-stage square root, then the two
// arctangent pipelines of one rotation per stage plus a pre-rotation stage. Throughput
// is one sample per cycle; input is refused only while a result sits unclaimed in the
// output register and the last stage holds another. The user must write offsets through
// the register port, which is always ready, while idle; the block does not enforce this.
`default_nettype none

module accel_tilt_angles_core import att_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  att_in_if.sink   in_ch,
  att_out_if.source out_ch,
  att_cfg_if.sink  cfg_ch
);

  off_t off_x_r, off_y_r, off_z_r;

  logic en;
  cal_t cal_x, cal_y, cal_z;
  cal_t abs_x, abs_y;

  // front stages
  logic v1_r, v2_r, v3_r;
  cal_t x1_r, y1_r, z1_r;
  logic [AB_W-1:0] ax2_r, ay2_r;
  cal_t x2_r, z2_r;
  logic dg2_r, zz2_r;
  logic [SQ_W-1:0] sqx3_r, sqy3_r;
  logic [AB_W-1:0] ay3_r;
  cal_t x3_r, z3_r;
  logic dg3_r, zz3_r;
  logic [SUM_W-1:0] sum_full;

  // square root stages
  logic            sv_r   [SQRT_STEPS+1];
  logic [SUM_W-1:0] nsh_r [SQRT_STEPS+1];
  logic [REM_W-1:0] rem_r [SQRT_STEPS+1];
  logic [ROOT_W-1:0] root_r [SQRT_STEPS+1];
  cal_t            sx_r   [SQRT_STEPS+1];
  cal_t            sz_r   [SQRT_STEPS+1];
  logic [AB_W-1:0] say_r  [SQRT_STEPS+1];
  logic            sdg_r  [SQRT_STEPS+1];
  logic            szz_r  [SQRT_STEPS+1];

  logic [REM_W-1:0]  rem_pre  [SQRT_STEPS];
  logic [REM_W-1:0]  rem_trl  [SQRT_STEPS];
  logic [REM_W-1:0]  rem_nxt  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_nxt [SQRT_STEPS];

  // arctangent stages: flags only, data lives in the rotation pipelines
  logic cv_r  [CORDIC_RUN+1];
  logic cdg_r [CORDIC_RUN+1];
  logic czz_r [CORDIC_RUN+1];

  cx_t  tilt_x, tilt_y, plane_x, plane_y;
  ang_t tilt_ang, plane_ang;

  logic out_valid_r;
  ang_t tilt_r, plane_r;
  logic degen_r;

  // advance whenever the output register can take or need not take the last stage
  assign en = out_ch.ready || !out_valid_r || !cv_r[CORDIC_RUN];

  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= OFF_X_RST;
      off_y_r <= OFF_Y_RST;
      off_z_r <= OFF_Z_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        CFG_OFFSET_X: off_x_r <= cfg_ch.wdata;
        CFG_OFFSET_Y: off_y_r <= cfg_ch.wdata;
        CFG_OFFSET_Z: off_z_r <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // axis remap plus offsets
  assign cal_x = cal_t'(in_ch.accel_raw_z) + cal_t'(off_x_r);
  assign cal_y = cal_t'(in_ch.accel_raw_y) + cal_t'(off_y_r);
  assign cal_z = cal_t'(in_ch.accel_raw_x) + cal_t'(off_z_r);

  assign abs_x = x1_r[CAL_W-1] ? -x1_r : x1_r;
  assign abs_y = y1_r[CAL_W-1] ? -y1_r : y1_r;

  // both squares stay below 2^31, so the sum fits without a carry bit
  assign sum_full = sqx3_r + sqy3_r;

  // one bit of the root per stage: root of (x^2 + y^2) * 2^32
  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      rem_pre[k] = {rem_r[k][REM_W-3:0], nsh_r[k][SUM_W-1 -: 2]};
      rem_trl[k] = {{(REM_W-ROOT_W-2){1'b0}}, root_r[k], 2'b01};
      if (rem_pre[k] >= rem_trl[k]) begin
        rem_nxt[k]  = rem_pre[k] - rem_trl[k];
        root_nxt[k] = {root_r[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_pre[k];
        root_nxt[k] = {root_r[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int k = 0; k <= SQRT_STEPS; k++) begin
        sv_r[k] <= 1'b0;
      end
      for (int j = 0; j <= CORDIC_RUN; j++) begin
        cv_r[j] <= 1'b0;
      end
    end else if (en) begin
      v1_r    <= in_ch.valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      sv_r[0] <= v3_r;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sv_r[k+1] <= sv_r[k];
      end
      cv_r[0] <= sv_r[SQRT_STEPS];
      for (int j = 0; j < CORDIC_RUN; j++) begin
        cv_r[j+1] <= cv_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= cal_x;
      y1_r <= cal_y;
      z1_r <= cal_z;

      ax2_r <= abs_x[AB_W-1:0];
      ay2_r <= abs_y[AB_W-1:0];
      x2_r  <= x1_r;
      z2_r  <= z1_r;
      dg2_r <= (x1_r == '0) && (y1_r == '0);
      zz2_r <= (z1_r == '0);

      sqx3_r <= SQ_W'(ax2_r) * SQ_W'(ax2_r);
      sqy3_r <= SQ_W'(ay2_r) * SQ_W'(ay2_r);
      ay3_r  <= ay2_r;
      x3_r   <= x2_r;
      z3_r   <= z2_r;
      dg3_r  <= dg2_r;
      zz3_r  <= zz2_r;

      nsh_r[0]  <= sum_full;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      sx_r[0]   <= x3_r;
      sz_r[0]   <= z3_r;
      say_r[0]  <= ay3_r;
      sdg_r[0]  <= dg3_r;
      szz_r[0]  <= zz3_r;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        nsh_r[k+1]  <= {nsh_r[k][SUM_W-3:0], 2'b00};
        rem_r[k+1]  <= rem_nxt[k];
        root_r[k+1] <= root_nxt[k];
        sx_r[k+1]   <= sx_r[k];
        sz_r[k+1]   <= sz_r[k];
        say_r[k+1]  <= say_r[k];
        sdg_r[k+1]  <= sdg_r[k];
        szz_r[k+1]  <= szz_r[k];
      end

      cdg_r[0] <= sdg_r[SQRT_STEPS];
      czz_r[0] <= szz_r[SQRT_STEPS];
      for (int j = 0; j < CORDIC_RUN; j++) begin
        cdg_r[j+1] <= cdg_r[j];
        czz_r[j+1] <= czz_r[j];
      end
    end
  end

  // scale z, x and |y| by 2^16 to match the 16 fraction bits of the root
  assign tilt_x  = {{(CX_W-CAL_W-FRAC_W){sz_r[SQRT_STEPS][CAL_W-1]}}, sz_r[SQRT_STEPS],
                    {FRAC_W{1'b0}}};
  assign tilt_y  = {{(CX_W-ROOT_W){1'b0}}, root_r[SQRT_STEPS]};
  assign plane_x = {{(CX_W-CAL_W-FRAC_W){sx_r[SQRT_STEPS][CAL_W-1]}}, sx_r[SQRT_STEPS],
                    {FRAC_W{1'b0}}};
  assign plane_y = {{(CX_W-AB_W-FRAC_W){1'b0}}, say_r[SQRT_STEPS], {FRAC_W{1'b0}}};

  att_cordic u_tilt (
    .clk   (clk),
    .en    (en),
    .x_in  (tilt_x),
    .y_in  (tilt_y),
    .angle (tilt_ang)
  );

  att_cordic u_plane (
    .clk   (clk),
    .en    (en),
    .x_in  (plane_x),
    .y_in  (plane_y),
    .angle (plane_ang)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= cv_r[CORDIC_RUN];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      // drop the angles where the vector gives no direction
      tilt_r  <= (cdg_r[CORDIC_RUN] && czz_r[CORDIC_RUN]) ? '0 : tilt_ang;
      plane_r <= cdg_r[CORDIC_RUN] ? '0 : plane_ang;
      degen_r <= cdg_r[CORDIC_RUN];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tilt_from_z = tilt_r;
  assign out_ch.plane_angle = plane_r;
  assign out_ch.degenerate  = degen_r;

endmodule

`default_nettype wire

// ----- hdl/att_checker.sv -----
// Port-level checks of the tilt angle block and their binding to the top level.
`default_nettype none

module att_checker import att_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire ang_t tilt_from_z,
  input wire ang_t plane_angle,
  input wire logic degenerate
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(tilt_from_z) && $stable(plane_angle)
                                && $stable(degenerate))
    else $error("stalled result beat changed");

  a_degen_plane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && degenerate |-> plane_angle == '0)
    else $error("plane angle nonzero with x and y both zero");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> tilt_from_z <= ANG_W'(ANG_MAX) && plane_angle <= ANG_W'(ANG_MAX))
    else $error("angle beyond 180 degrees");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with empty output register");

endmodule

bind accel_tilt_angles_core att_checker u_att_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .tilt_from_z (out_ch.tilt_from_z),
  .plane_angle (out_ch.plane_angle),
  .degenerate  (out_ch.degenerate)
);

`default_nettype wire
